// File: rtl/sba_pkg.sv
package sba_pkg;

	localparam int NUM_CHUNKS_DEF   = 16;
	localparam int CHUNK_BYTES_DEF  = 65536;
	localparam int HEADER_BYTES     = 16;
	localparam int CLASS_COUNT_DEF  = 7;
	localparam int CHUNK_HEAD_BYTES = 32;
	localparam int BLOCK_BITS       = 11;
	localparam int MAX_BLOCKS       = 2047;
	localparam int CHUNK_BITS       = 4;
	localparam int ADDR_BITS        = CHUNK_BITS + BLOCK_BITS;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_NO_MEM    = 3'd2,
		ST_DBL_FREE  = 3'd3,
		ST_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture input word, issue memory reads
		logic exec;   // read data valid: decide, update state
		logic pop;    // output word taken
	} cmd_t;

	typedef struct packed {
		logic out_valid;
	} stat_t;

	function automatic logic [10:0] class_bytes(input logic [2:0] c);
		logic [10:0] r;
		case (c)
			3'd0: r = 11'd16;
			3'd1: r = 11'd32;
			3'd2: r = 11'd64;
			3'd3: r = 11'd128;
			3'd4: r = 11'd256;
			3'd5: r = 11'd512;
			3'd6: r = 11'd1024;
			default: r = 11'd16;
		endcase
		return r;
	endfunction

	// blocks per chunk for a class
	function automatic logic [10:0] blocks_of(input int chunk_bytes, input logic [2:0] c);
		int n;
		case (c)
			3'd0: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 32;
			3'd1: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 48;
			3'd2: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 80;
			3'd3: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 144;
			3'd4: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 272;
			3'd5: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 528;
			default: n = (chunk_bytes - CHUNK_HEAD_BYTES) / 1040;
		endcase
		if (n > MAX_BLOCKS)
			n = MAX_BLOCKS;
		return n[10:0];
	endfunction

endpackage

// File: rtl/sba_ram.sv
module sba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sba_ctrl.sv
module sba_ctrl
	import sba_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  out_ready,
	input  logic  clr_busy,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				// output register may still hold a word; accept once it is free or leaving
				in_ready = !clr_busy && (!stat.out_valid || out_ready);
				cmd.pop  = stat.out_valid && out_ready;
				if (in_ready && in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/sba_dp.sv
module sba_dp
	import sba_pkg::*;
#(
	parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
	parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        clr_busy,
	input  logic        mode,
	input  logic [31:0] request_size,
	input  logic [3:0]  chunk_index,
	input  logic [10:0] block_index,
	output logic [2:0]  status,
	output logic [2:0]  size_class,
	output logic [3:0]  out_chunk,
	output logic [10:0] out_block
);

	localparam int CHUNK_LIMIT = (NUM_CHUNKS < 16) ? NUM_CHUNKS : 16;
	localparam int SLOTS       = CHUNK_LIMIT * 2048;
	localparam int SA          = $clog2(SLOTS);

	// captured request
	logic        mode_q, big_q;
	logic [2:0]  cls_q;
	logic [3:0]  ch_q;
	logic [10:0] bl_q;

	// per-class and chunk bookkeeping
	logic        head_v_q [7];
	logic [14:0] head_q   [7];
	logic [3:0]  carve_ch_q [7];
	logic [10:0] carve_left_q [7];
	logic [4:0]  claimed_q;
	logic [2:0]  chunk_cls_q [16];

	// clearing pass over the allocated-bit memory
	logic [SA:0] clr_q;

	logic [2:0] req_cls;
	logic       req_big;
	logic [31:0] sz;
	always_comb begin
		sz = (request_size == 32'd0) ? 32'd1 : request_size;
		req_big = 1'b1;
		req_cls = 3'd0;
		for (int c = 6; c >= 0; c--) begin
			if (c < CLASS_COUNT && sz <= {21'd0, class_bytes(c[2:0])}) begin
				req_big = 1'b0;
				req_cls = c[2:0];
			end
		end
	end

	logic [ADDR_BITS-1:0] free_addr, pop_addr;
	logic [SA-1:0] alloc_raddr, link_raddr;
	assign free_addr = {chunk_index, block_index};
	assign pop_addr  = head_q[req_cls];
	// allocated bit is read at the freed block; link at the popped block
	assign alloc_raddr = free_addr[SA-1:0];
	assign link_raddr  = pop_addr[SA-1:0];

	logic        alloc_rd;
	logic [15:0] link_rd;
	logic        a_we, l_we;
	logic [SA-1:0] a_wa, l_wa;
	logic        a_wd;
	logic [15:0] l_wd;

	sba_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_alloc (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd),
		.raddr(alloc_raddr), .rdata(alloc_rd)
	);
	sba_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_link (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd),
		.raddr(link_raddr), .rdata(link_rd)
	);

	assign clr_busy = !clr_q[SA];

	// execute-stage decision
	logic [2:0]  r_st, r_cls, fcls;
	logic [3:0]  r_ch;
	logic [10:0] r_bl, nblk, fblk, left_m1;
	logic        do_pop, do_carve, do_claim, do_push;
	logic [ADDR_BITS-1:0] alloc_addr, fa;
	always_comb begin
		r_st = ST_OK; r_cls = '0; r_ch = '0; r_bl = '0;
		do_pop = 1'b0; do_carve = 1'b0; do_claim = 1'b0; do_push = 1'b0;
		nblk = blocks_of(CHUNK_BYTES, cls_q);
		fcls = chunk_cls_q[ch_q];
		fblk = blocks_of(CHUNK_BYTES, fcls);
		fa = {ch_q, bl_q};
		left_m1 = carve_left_q[cls_q] - 11'd1;
		alloc_addr = head_q[cls_q];
		if (!mode_q) begin
			if (big_q) begin
				r_st = ST_TOO_LARGE;
			end else if (head_v_q[cls_q]) begin
				do_pop = 1'b1;
				r_cls = cls_q;
			end else if (carve_left_q[cls_q] != 11'd0) begin
				do_carve = 1'b1;
				r_cls = cls_q;
				alloc_addr = {carve_ch_q[cls_q], left_m1};
			end else if ({27'd0, claimed_q} >= CHUNK_LIMIT || nblk == 11'd0) begin
				r_st = ST_NO_MEM;
				r_cls = cls_q;
			end else begin
				do_claim = 1'b1;
				r_cls = cls_q;
				alloc_addr = {claimed_q[3:0], nblk - 11'd1};
			end
			if (r_st == ST_OK) begin
				r_ch = alloc_addr[14:11];
				r_bl = alloc_addr[10:0];
			end
		end else begin
			if ({1'b0, ch_q} >= claimed_q || bl_q >= fblk) begin
				r_st = ST_BAD_FREE;
			end else if (!alloc_rd) begin
				r_st = ST_DBL_FREE;
				r_cls = fcls;
			end else begin
				do_push = 1'b1;
				r_cls = fcls;
			end
		end
	end

	always_comb begin
		a_we = 1'b0; a_wa = '0; a_wd = 1'b0;
		l_we = 1'b0; l_wa = fa[SA-1:0]; l_wd = {head_v_q[fcls], head_q[fcls]};
		if (clr_busy) begin
			a_we = 1'b1; a_wa = clr_q[SA-1:0];
		end else if (cmd.exec) begin
			if (do_pop || do_carve || do_claim) begin
				a_we = 1'b1; a_wa = alloc_addr[SA-1:0]; a_wd = 1'b1;
			end else if (do_push) begin
				a_we = 1'b1; a_wa = fa[SA-1:0];
				l_we = 1'b1;
			end
		end
	end

	logic        ov_q;
	logic [2:0]  st_q, sc_q;
	logic [3:0]  oc_q;
	logic [10:0] ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			clr_q <= '0;
			claimed_q <= '0;
			for (int c = 0; c < 7; c++) begin
				head_v_q[c] <= 1'b0;
				carve_ch_q[c] <= '0;
				carve_left_q[c] <= '0;
			end
		end else begin
			if (clr_busy)
				clr_q <= clr_q + 1'b1;
			if (cmd.pop)
				ov_q <= 1'b0;
			if (cmd.exec) begin
				ov_q <= 1'b1;
				if (do_pop)
					head_v_q[cls_q] <= link_rd[15];
				if (do_push)
					head_v_q[fcls] <= 1'b1;
				if (do_carve)
					carve_left_q[cls_q] <= left_m1;
				if (do_claim) begin
					carve_left_q[cls_q] <= nblk - 11'd1;
					carve_ch_q[cls_q] <= claimed_q[3:0];
					claimed_q <= claimed_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			big_q  <= req_big;
			cls_q  <= req_cls;
			ch_q   <= chunk_index;
			bl_q   <= block_index;
		end
		if (cmd.exec) begin
			st_q <= r_st; sc_q <= r_cls; oc_q <= r_ch; ob_q <= r_bl;
			if (do_pop)
				head_q[cls_q] <= link_rd[14:0];
			if (do_push)
				head_q[fcls] <= fa;
			if (do_claim)
				chunk_cls_q[claimed_q[3:0]] <= cls_q;
		end
	end

	// each link entry holds the previous stack head, valid flag in bit 15
	assign stat.out_valid = ov_q;
	assign status     = st_q;
	assign size_class = sc_q;
	assign out_chunk  = oc_q;
	assign out_block  = ob_q;

endmodule

// File: rtl/slab_block_allocator_unit.sv
// The result word is registered in the execute state that follows acceptance of the input word.
// A new input word is not accepted while the previous one executes (read then write of the block memories).
// Reset: arst_n clears all control state; afterwards a clearing pass sweeps
// NUM_CHUNKS*2048 entries (at most 16 chunks, rounded up to a power of two)
// of the allocated-bit memory while no input word is accepted.
module slab_block_allocator_unit
	import sba_pkg::*;
#(
	parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
	parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // mode, request_size[31:0], chunk_index[3:0], block_index[10:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[2:0], size_class[2:0], out_chunk[3:0], out_block[10:0], pad
);

	cmd_t  cmd;
	stat_t stat;
	logic  clr_busy;
	logic [2:0]  st, sc;
	logic [3:0]  oc;
	logic [10:0] ob;

	sba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_ready(m_tready), .clr_busy(clr_busy), .stat(stat), .cmd(cmd)
	);

	sba_dp #(.NUM_CHUNKS(NUM_CHUNKS), .CHUNK_BYTES(CHUNK_BYTES),
		.CLASS_COUNT(CLASS_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .clr_busy(clr_busy),
		.mode(s_tdata[0]), .request_size(s_tdata[32:1]),
		.chunk_index(s_tdata[36:33]), .block_index(s_tdata[47:37]),
		.status(st), .size_class(sc), .out_chunk(oc), .out_block(ob)
	);

	assign m_tvalid = stat.out_valid;
	assign m_tdata  = {3'd0, ob, oc, sc, st};

endmodule

// File: tb/sv/slab_block_allocator_unit_test.sv
`timescale 1ns / 1ps

module slab_block_allocator_unit_test
	import sba_pkg::*;
();

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   SLOTS = 16 * 2048;

	typedef struct packed {
		status_t     status;
		logic [2:0]  cls;
		logic [3:0]  chunk;
		logic [10:0] block;
	} alloc_result_t;

	typedef struct packed {
		logic [3:0]  chunk;
		logic [10:0] block;
	} handle_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	slab_block_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// allocator shadow state
	bit          in_use [SLOTS];
	logic [15:0] link_below [SLOTS];
	logic [15:0] free_top [7];
	logic [3:0]  carving_chunk [7];
	logic [10:0] carve_remaining [7];
	logic [4:0]  claimed;
	logic [2:0]  owner_class [16];

	alloc_result_t pending_results [$];
	handle_t       live [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int cycles;
	int errors;
	int words_in;
	int words_out;
	int oom_seen;
	int dbl_seen;
	int bad_seen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when hold_left is set
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic int blocks_per_chunk(input logic [2:0] c);
		int n;
		n = (65536 - 32) / (16 + (16 << c));
		return (n > 2047) ? 2047 : n;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", words_out, what, got, want);
		errors++;
	endtask

	function automatic alloc_result_t predict(input logic mode, input logic [31:0] size,
		input logic [3:0] ch, input logic [10:0] bl);
		alloc_result_t r;
		logic [2:0] c;
		int addr;
		int n;
		bit fits;
		r = '{status: ST_OK, cls: 3'd0, chunk: 4'd0, block: 11'd0};
		if (mode == MODE_FREE) begin
			if (ch >= claimed || bl >= blocks_per_chunk(owner_class[ch])) begin
				r.status = ST_BAD_FREE;
				return r;
			end
			r.cls = owner_class[ch];
			addr = ch * 2048 + bl;
			if (!in_use[addr]) begin
				r.status = ST_DBL_FREE;
				return r;
			end
			in_use[addr] = 1'b0;
			link_below[addr] = free_top[r.cls];
			free_top[r.cls] = {1'b1, 15'(addr)};
			return r;
		end
		if (size == 0)
			size = 1;
		fits = 1'b0;
		c = 3'd0;
		for (int k = 6; k >= 0; k--)
			if (size <= (32'd16 << k)) begin
				c = 3'(k);
				fits = 1'b1;
			end
		if (!fits) begin
			r.status = ST_TOO_LARGE;
			return r;
		end
		r.cls = c;
		if (free_top[c][15]) begin
			addr = int'(free_top[c][14:0]);
			free_top[c] = link_below[addr];
		end else begin
			if (carve_remaining[c] == 0) begin
				n = blocks_per_chunk(c);
				if (claimed >= 16 || n == 0) begin
					r.status = ST_NO_MEM;
					return r;
				end
				carving_chunk[c] = claimed[3:0];
				owner_class[claimed[3:0]] = c;
				claimed++;
				carve_remaining[c] = 11'(n);
			end
			carve_remaining[c]--;
			addr = carving_chunk[c] * 2048 + carve_remaining[c];
		end
		in_use[addr] = 1'b1;
		r.chunk = addr[14:11];
		r.block = addr[10:0];
		return r;
	endfunction

	task automatic send_word(input logic mode, input logic [31:0] size,
		input logic [3:0] ch, input logic [10:0] bl);
		alloc_result_t r;
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r = predict(mode, size, ch, bl);
		pending_results.push_back(r);
		case (r.status)
			ST_NO_MEM:   oom_seen++;
			ST_DBL_FREE: dbl_seen++;
			ST_BAD_FREE: bad_seen++;
			default: ;
		endcase
		if (mode == MODE_ALLOC && r.status == ST_OK)
			live.push_back('{chunk: r.chunk, block: r.block});
		s_tvalid <= 1'b1;
		s_tdata  <= {bl, ch, size, mode};
		do @(posedge clk); while (!s_tready);
		words_in++;
	endtask

	task automatic alloc(input logic [31:0] size);
		send_word(MODE_ALLOC, size, 4'd0, 11'd0);
	endtask

	task automatic free_handle(input logic [3:0] ch, input logic [10:0] bl);
		send_word(MODE_FREE, $urandom, ch, bl);
	endtask

	task automatic free_live(input int idx);
		handle_t h;
		h = live[idx];
		live.delete(idx);
		free_handle(h.chunk, h.block);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("result word with nothing pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[2:0] != want.status)
					report_mismatch("status", m_tdata[2:0], want.status);
				if (m_tdata[5:3] != want.cls)
					report_mismatch("size_class", m_tdata[5:3], want.cls);
				if (m_tdata[9:6] != want.chunk)
					report_mismatch("out_chunk", m_tdata[9:6], want.chunk);
				if (m_tdata[20:10] != want.block)
					report_mismatch("out_block", m_tdata[20:10], want.block);
				if (m_tdata[23:21] != 3'd0)
					report_mismatch("pad", m_tdata[23:21], 0);
			end
			words_out++;
		end
	end

	task automatic test_directed();
		int first;
		// free before anything is claimed
		free_handle(4'd15, 11'd2046);
		free_handle(4'd0, 11'd0);
		alloc(32'd0);
		alloc(32'd1);
		alloc(32'd16);
		alloc(32'd17);
		alloc(32'd64);
		alloc(32'd65);
		alloc(32'd256);
		alloc(32'd512);
		alloc(32'd1024);
		alloc(32'd1025);
		alloc(32'hFFFF_FFFF);
		alloc(32'h8000_0000);
		first = 0;
		free_handle(live[first].chunk, live[first].block);
		// second free of the same block
		free_handle(live[first].chunk, live[first].block);
		live.delete(first);
		alloc(32'd8);                // pops the freed block
		free_handle(4'd0, 11'd0);     // never carved
		free_handle(4'd0, 11'd2047);  // past class 0 count
		free_handle(4'd6, 11'd62);    // past class 6 count
		free_handle(4'd6, 11'd61);
		free_handle(4'd14, 11'd5);    // unclaimed chunk
		drain();
	endtask

	task automatic random_mix(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				alloc($urandom_range(0, 16 << $urandom_range(0, 6)));
			else if (pick < 55)
				alloc($urandom);
			else if (pick < 90 && live.size() != 0)
				free_live($urandom_range(0, live.size() - 1));
			else
				free_handle(4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
		end
	endtask

	task automatic test_random_idling();
		send_idle_pct = 0;  recv_stall_pct = 0;  random_mix(40); drain();
		send_idle_pct = 46; recv_stall_pct = 0;  random_mix(40); drain();
		send_idle_pct = 0;  recv_stall_pct = 46; random_mix(40); drain();
		send_idle_pct = 12; recv_stall_pct = 12; random_mix(40); drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		random_mix(24);
		drain();
	endtask

	task automatic test_exhaustion();
		send_idle_pct = 12;
		recv_stall_pct = 12;
		while (oom_seen < 3)
			alloc($urandom_range(513, 1024));
		for (int i = 0; i < 30 && live.size() != 0; i++)
			free_live($urandom_range(0, live.size() - 1));
		random_mix(30);
		for (int c = 0; c < 7; c++)
			alloc(16 << c);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int c = 0; c < 7; c++) begin
			free_top[c] = '0;
			carving_chunk[c] = '0;
			carve_remaining[c] = '0;
		end
		claimed = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_idling();
		test_backpressure();
		test_exhaustion();
		$display("%0d words in, %0d out; %0d chunks claimed", words_in, words_out, claimed);
		$display("out of memory %0d, double free %0d, invalid free %0d",
			oom_seen, dbl_seen, bad_seen);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
